[design/pfa_pkg.sv]
// Shared constants and the arctangent table for the potential-field avoidance block.
package pfa_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 1'd1;

	localparam logic signed [15:0] START_ANGLE_RST = -16'sd25736;
	localparam logic [13:0]        ANGLE_STEP_RST  = 14'd71;

	localparam logic signed [18:0] PI_Q13      = 19'sd25736;
	localparam logic signed [18:0] HALF_PI_Q13 = 19'sd12868;
	localparam logic signed [18:0] TWO_PI_Q13  = 19'sd51472;

	localparam logic signed [31:0] LIMIT_Q15 = 32'sd9830;

	localparam int CORDIC_ITERS = 16;
	localparam int MEAN_BITS    = 32;
	localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

	function automatic logic [29:0] atan_q29(input logic [3:0] i);
		logic [29:0] r;
		case (i)
			4'd0:    r = 30'd421657428;
			4'd1:    r = 30'd248918914;
			4'd2:    r = 30'd131521919;
			4'd3:    r = 30'd66762579;
			4'd4:    r = 30'd33510844;
			4'd5:    r = 30'd16771758;
			4'd6:    r = 30'd8387925;
			4'd7:    r = 30'd4194219;
			4'd8:    r = 30'd2097141;
			4'd9:    r = 30'd1048575;
			4'd10:   r = 30'd524288;
			4'd11:   r = 30'd262144;
			4'd12:   r = 30'd131072;
			4'd13:   r = 30'd65536;
			4'd14:   r = 30'd32768;
			default: r = 30'd16384;
		endcase
		return r;
	endfunction

endpackage

[design/potential_field_avoidance.sv]
// Potential-field avoidance: per-sample weight and CORDIC, scan sums and serial means.
// Each range item is worked in order: the distance is squared as it is taken, the divider is
// set up, then a restoring divider forms the weight one quotient bit per cycle while a CORDIC
// unit runs one rotation per cycle, then the terms are multiplied and accumulated. An item
// flagged as the last of its scan then has two serial dividers form the means one quotient
// bit per cycle, before the result item is loaded into the output register. Samples past
// MAX_SAMPLES in a scan are dropped. in_stall is high while an item is in work; a waiting
// result does not hold up range items, only the next scan end.
module potential_field_avoidance (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [15:0]                           distance,
	input  logic                                  last_sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [14:0]                           linear_speed,
	output logic signed [15:0]                    angular_speed,
	input  logic                                  cfg_we,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pfa_pkg::CFG_DATA_W-1:0]        cfg_data
);

	typedef enum logic [2:0] {IDLE, SETUP, ITER, TERM, ACC, MPREP, MEAN, FIN} state_t;

	state_t                         state_q;
	logic [4:0]                     iter_q;
	logic                           last_q;
	logic signed [15:0]             start_angle_q;
	logic [13:0]                    angle_step_q;
	logic signed [17:0]             cur_angle_q;
	logic [pfa_pkg::CNT_W-1:0]      count_q;
	logic signed [31:0]             lsum_q, rsum_q;
	logic [31:0]                    dsq_q;
	logic [32:0]                    den_q;
	logic [33:0]                    rem_q;
	logic [15:0]                    numsh_q;
	logic [15:0]                    w_q;
	logic signed [33:0]             x_q, y_q;
	logic signed [32:0]             z_q;
	logic                           neg_q;
	logic signed [32:0]             prod_c_q, prod_s_q;
	logic                           lneg_q, rneg_q;
	logic [31:0]                    lmag_q, rmag_q;
	logic [pfa_pkg::CNT_W-1:0]      lrem_q, rrem_q;
	logic                           out_valid_q;
	logic [14:0]                    lin_out_q;
	logic signed [15:0]             rot_out_q;

	// angle reduction and fold into [-pi/2, pi/2]
	logic signed [18:0] a_red, a_fold;
	logic               a_neg;
	always_comb begin
		a_red = 19'(cur_angle_q);
		if (a_red >= pfa_pkg::PI_Q13)
			a_red = a_red - pfa_pkg::TWO_PI_Q13;
		if (a_red < -pfa_pkg::PI_Q13)
			a_red = a_red + pfa_pkg::TWO_PI_Q13;
		a_fold = a_red;
		a_neg  = 1'b0;
		if (a_red > pfa_pkg::HALF_PI_Q13) begin
			a_fold = a_red - pfa_pkg::PI_Q13;
			a_neg  = 1'b1;
		end else if (a_red < -pfa_pkg::HALF_PI_Q13) begin
			a_fold = a_red + pfa_pkg::PI_Q13;
			a_neg  = 1'b1;
		end
	end

	// weight divider set-up: N = 2^31 + den/2
	logic [32:0] den_c;
	logic [33:0] num_c;
	assign den_c = {1'b0, dsq_q} + 33'd65536;
	assign num_c = 34'h0_8000_0000 + {2'b0, den_c[32:1]};

	// one restoring step of the weight divider
	logic [33:0] wrs;
	logic        wbit;
	assign wrs  = {rem_q[32:0], numsh_q[15]};
	assign wbit = wrs >= {1'b0, den_q};

	// one CORDIC rotation
	logic [3:0]         ci;
	logic signed [33:0] dx, dy;
	logic signed [32:0] at;
	assign ci = iter_q[3:0];
	assign dx = y_q >>> ci;
	assign dy = x_q >>> ci;
	assign at = 33'(pfa_pkg::atan_q29(ci));

	// rounding, sign fold and saturation of the CORDIC outputs
	logic signed [33:0] xr, yr;
	logic signed [15:0] cos_c, sin_c;
	always_comb begin
		xr = (x_q + 34'sd16384) >>> 15;
		yr = (y_q + 34'sd16384) >>> 15;
		if (neg_q) begin
			xr = -xr;
			yr = -yr;
		end
		if (xr > 34'sd32767)       cos_c = 16'sd32767;
		else if (xr < -34'sd32767) cos_c = -16'sd32767;
		else                       cos_c = 16'(xr);
		if (yr > 34'sd32767)       sin_c = 16'sd32767;
		else if (yr < -34'sd32767) sin_c = -16'sd32767;
		else                       sin_c = 16'(yr);
	end

	logic signed [32:0] term_c, term_s;
	assign term_c = (prod_c_q + 33'sd16384) >>> 15;
	assign term_s = (prod_s_q + 33'sd16384) >>> 15;

	logic signed [18:0] na;
	always_comb begin
		na = 19'(cur_angle_q) + 19'(signed'({1'b0, angle_step_q}));
		if (na >= pfa_pkg::PI_Q13)
			na = na - pfa_pkg::TWO_PI_Q13;
	end

	// serial mean dividers
	logic [pfa_pkg::CNT_W:0] lrs, rrs;
	logic                    lbit, rbit;
	assign lrs  = {lrem_q, lmag_q[31]};
	assign rrs  = {rrem_q, rmag_q[31]};
	assign lbit = lrs >= {1'b0, count_q};
	assign rbit = rrs >= {1'b0, count_q};

	logic signed [31:0] lin_c, rot_c;
	always_comb begin
		lin_c = lneg_q ? -signed'(lmag_q) : signed'(lmag_q);
		rot_c = rneg_q ? -signed'(rmag_q) : signed'(rmag_q);
		if (lin_c > pfa_pkg::LIMIT_Q15)
			lin_c = pfa_pkg::LIMIT_Q15;
		else if (lin_c < -pfa_pkg::LIMIT_Q15)
			lin_c = -pfa_pkg::LIMIT_Q15;
	end

	logic sample_ok;
	assign sample_ok = count_q < pfa_pkg::CNT_W'(pfa_pkg::MAX_SAMPLES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			iter_q        <= '0;
			last_q        <= 1'b0;
			start_angle_q <= pfa_pkg::START_ANGLE_RST;
			angle_step_q  <= pfa_pkg::ANGLE_STEP_RST;
			cur_angle_q   <= 18'(pfa_pkg::START_ANGLE_RST);
			count_q       <= '0;
			lsum_q        <= '0;
			rsum_q        <= '0;
			dsq_q         <= '0;
			den_q         <= '0;
			rem_q         <= '0;
			numsh_q       <= '0;
			w_q           <= '0;
			x_q           <= '0;
			y_q           <= '0;
			z_q           <= '0;
			neg_q         <= 1'b0;
			prod_c_q      <= '0;
			prod_s_q      <= '0;
			lneg_q        <= 1'b0;
			rneg_q        <= 1'b0;
			lmag_q        <= '0;
			rmag_q        <= '0;
			lrem_q        <= '0;
			rrem_q        <= '0;
			out_valid_q   <= 1'b0;
			lin_out_q     <= '0;
			rot_out_q     <= '0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					pfa_pkg::REG_START_ANGLE: begin
						start_angle_q <= signed'(cfg_data);
						if (count_q == '0)
							cur_angle_q <= 18'(signed'(cfg_data));
					end
					pfa_pkg::REG_ANGLE_STEP: angle_step_q <= cfg_data[13:0];
					default: ;
				endcase
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						last_q <= last_sample;
						if (sample_ok) begin
							dsq_q   <= 32'(distance) * 32'(distance);
							x_q     <= pfa_pkg::CORDIC_K;
							y_q     <= '0;
							z_q     <= 33'(a_fold) <<< 16;
							neg_q   <= a_neg;
							state_q <= SETUP;
						end else if (last_sample) begin
							state_q <= MPREP;
						end
					end
				end
				SETUP: begin
					den_q   <= den_c;
					rem_q   <= {16'b0, num_c[33:16]};
					numsh_q <= num_c[15:0];
					w_q     <= '0;
					iter_q  <= '0;
					state_q <= ITER;
				end
				ITER: begin
					rem_q   <= wbit ? wrs - {1'b0, den_q} : wrs;
					numsh_q <= {numsh_q[14:0], 1'b0};
					w_q     <= {w_q[14:0], wbit};
					if (z_q >= 0) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + at;
					end
					iter_q <= iter_q + 5'd1;
					if (iter_q == 5'(pfa_pkg::CORDIC_ITERS - 1))
						state_q <= TERM;
				end
				TERM: begin
					prod_c_q <= 33'(cos_c) * 33'(signed'({1'b0, w_q}));
					prod_s_q <= 33'(sin_c) * 33'(signed'({1'b0, w_q}));
					state_q  <= ACC;
				end
				ACC: begin
					lsum_q      <= lsum_q - 32'(term_c);
					rsum_q      <= rsum_q - 32'(term_s);
					count_q     <= count_q + pfa_pkg::CNT_W'(1);
					cur_angle_q <= 18'(na);
					state_q     <= last_q ? MPREP : IDLE;
				end
				MPREP: begin
					lneg_q  <= lsum_q[31];
					rneg_q  <= rsum_q[31];
					lmag_q  <= lsum_q[31] ? 32'(-lsum_q) : 32'(lsum_q);
					rmag_q  <= rsum_q[31] ? 32'(-rsum_q) : 32'(rsum_q);
					lrem_q  <= '0;
					rrem_q  <= '0;
					iter_q  <= '0;
					state_q <= MEAN;
				end
				MEAN: begin
					lrem_q <= lbit ? pfa_pkg::CNT_W'(lrs - {1'b0, count_q})
					               : pfa_pkg::CNT_W'(lrs);
					rrem_q <= rbit ? pfa_pkg::CNT_W'(rrs - {1'b0, count_q})
					               : pfa_pkg::CNT_W'(rrs);
					lmag_q <= {lmag_q[30:0], lbit};
					rmag_q <= {rmag_q[30:0], rbit};
					iter_q <= iter_q + 5'd1;
					if (iter_q == 5'(pfa_pkg::MEAN_BITS - 1))
						state_q <= FIN;
				end
				FIN: begin
					// wait for the output register to drain
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						if (count_q == '0) begin
							lin_out_q <= '0;
							rot_out_q <= '0;
						end else begin
							lin_out_q <= 15'(lin_c + pfa_pkg::LIMIT_Q15);
							rot_out_q <= 16'(rot_c);
						end
						lsum_q      <= '0;
						rsum_q      <= '0;
						count_q     <= '0;
						cur_angle_q <= 18'(start_angle_q);
						state_q     <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_stall      = state_q != IDLE;
	assign out_valid     = out_valid_q;
	assign linear_speed  = lin_out_q;
	assign angular_speed = rot_out_q;

`ifndef NO_ASSERTIONS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pfa_pkg::CNT_W'(pfa_pkg::MAX_SAMPLES))
		else $error("sample count past limit");
	a_weight_max: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == TERM |-> w_q <= 16'd32768 && w_q != '0)
		else $error("weight out of range");
	a_lin_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> lin_out_q <= 15'd19660)
		else $error("linear speed out of range");
	a_scan_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FIN && (!out_valid_q || !out_stall) |=>
		count_q == '0 && lsum_q == '0 && rsum_q == '0 && out_valid_q)
		else $error("scan end did not clear sums");
`endif

endmodule

[verif/pfa_checker.sv]
// Checker for the potential-field avoidance block: predicts each scan result and compares it.
`timescale 1ns / 1ps
module pfa_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [15:0]                        distance,
	input  logic                               last_sample,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [14:0]                        linear_speed,
	input  logic signed [15:0]                 angular_speed,
	input  logic                               cfg_we,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfa_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                 errors,
	output int                                 pending
);

	localparam longint PI_A     = 25736;
	localparam longint HALF_PI_A = 12868;
	localparam longint TWO_PI_A = 51472;
	localparam longint CLAMP    = 9830;
	localparam longint GAIN     = 652032874;
	localparam longint ARCTAN [16] = '{421657428, 248918914, 131521919, 66762579, 33510844,
		16771758, 8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536, 32768,
		16384};

	typedef struct packed {
		logic [14:0]        lin;
		logic signed [15:0] ang;
	} speed_cmd_t;

	speed_cmd_t speed_q[$];
	longint     scan_lin_sum, scan_rot_sum, scan_angle, first_angle, step_size;
	int         scan_count;

	assign pending = speed_q.size();

	function automatic longint sat_unit(input longint v);
		if (v > 32767) return 32767;
		if (v < -32767) return -32767;
		return v;
	endfunction

	// Returns {sin, cos} of a Q3.13 angle, both Q1.15
	function automatic void sin_cos(input longint ang, output longint s, output longint c);
		longint a, x, y, z, dx, dy;
		bit     flip;
		a = ang % TWO_PI_A;
		flip = 0;
		if (a >= PI_A) a -= TWO_PI_A;
		if (a < -PI_A) a += TWO_PI_A;
		if (a > HALF_PI_A) begin
			a -= PI_A; flip = 1;
		end else if (a < -HALF_PI_A) begin
			a += PI_A; flip = 1;
		end
		x = GAIN; y = 0; z = a * 65536;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARCTAN[i];
			end else begin
				x += dx; y -= dy; z += ARCTAN[i];
			end
		end
		x = (x + 16384) >>> 15;
		y = (y + 16384) >>> 15;
		if (flip) begin
			x = -x; y = -y;
		end
		c = sat_unit(x);
		s = sat_unit(y);
	endfunction

	function automatic longint mean_toward_zero(input longint sum, input int n);
		longint q;
		q = (sum < 0 ? -sum : sum) / n;
		return sum < 0 ? -q : q;
	endfunction

	task automatic take_range(input logic [15:0] d, input logic fin);
		longint den, w, s, c, na, lm, rm;
		speed_cmd_t cmd;
		if (scan_count < pfa_pkg::MAX_SAMPLES) begin
			den = longint'(d) * longint'(d) + 65536;
			w = (64'd2147483648 + den / 2) / den;
			sin_cos(scan_angle, s, c);
			scan_lin_sum -= (c * w + 16384) >>> 15;
			scan_rot_sum -= (s * w + 16384) >>> 15;
			scan_count++;
			na = scan_angle + step_size;
			if (na >= PI_A) na -= TWO_PI_A;
			scan_angle = na;
		end
		if (fin) begin
			if (scan_count == 0) begin
				cmd = '0;
			end else begin
				lm = mean_toward_zero(scan_lin_sum, scan_count);
				rm = mean_toward_zero(scan_rot_sum, scan_count);
				if (lm > CLAMP) lm = CLAMP;
				else if (lm < -CLAMP) lm = -CLAMP;
				cmd.lin = 15'(lm + CLAMP);
				cmd.ang = 16'(rm);
			end
			speed_q.push_back(cmd);
			scan_lin_sum = 0; scan_rot_sum = 0; scan_count = 0;
			scan_angle = first_angle;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		speed_cmd_t want;
		if (!arst_n) begin
			speed_q.delete();
			errors = 0;
			first_angle = pfa_pkg::START_ANGLE_RST;
			step_size = pfa_pkg::ANGLE_STEP_RST;
			scan_lin_sum = 0; scan_rot_sum = 0; scan_count = 0;
			scan_angle = first_angle;
		end else begin
			if (out_valid && !out_stall) begin
				if (speed_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result lin=%0d ang=%0d", $realtime,
							linear_speed, angular_speed);
				end else begin
					want = speed_q.pop_front();
					if (want.lin !== linear_speed || want.ang !== angular_speed) begin
						errors++;
						if (errors <= 10)
							$display("%0t: result mismatch lin exp %0d got %0d, ang exp %0d got %0d",
								$realtime, want.lin, linear_speed, want.ang, angular_speed);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					pfa_pkg::REG_START_ANGLE: begin
						first_angle = longint'($signed(cfg_data));
						if (scan_count == 0) scan_angle = first_angle;
					end
					pfa_pkg::REG_ANGLE_STEP: step_size = cfg_data[13:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				take_range(distance, last_sample);
		end
	end
endmodule

[verif/tb_top.sv]
// Top of the potential-field avoidance testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int SETTLE      = 80;

	logic                           clk, arst_n;
	logic                           in_valid, in_stall, last_sample;
	logic [15:0]                    distance;
	logic                           out_valid, out_stall;
	logic [14:0]                    linear_speed;
	logic signed [15:0]             angular_speed;
	logic                           cfg_we;
	logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data;
	int                             errors, pending, cycles, burst_left, stall_mode;

	potential_field_avoidance dut (.*);

	pfa_checker chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver stall pattern: one of four stall modes, picked at random
	always @(negedge clk) begin
		if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(0, 9) < 3);
			2:       out_stall <= ($urandom_range(0, 9) < 8);
			default: out_stall <= (cycles % 16) < 8;
		endcase
	end

	function automatic logic [15:0] pick_range();
		case ($urandom_range(0, 4))
			0:       return 16'($urandom_range(0, 511));
			1:       return 16'($urandom_range(0, 2047));
			2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_range(input logic [15:0] d, input logic fin);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 10)) @(negedge clk);
			burst_left = $urandom_range(1, 30);
		end
		in_valid = 1'b1;
		distance = d;
		last_sample = fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [pfa_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] v);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_scans(input int n);
		int len;
		while (n > 0) begin
			len = $urandom_range(0, 7) == 0 ? $urandom_range(41, 120) : $urandom_range(1, 40);
			for (int i = 0; i < len; i++)
				send_range(pick_range(), i == len - 1);
			n -= len;
			if ($urandom_range(0, 15) == 0) drain();
		end
		drain();
	endtask

	initial begin
		logic [15:0] edge_ranges [8];
		edge_ranges = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0100, 16'h8000, 16'h00FF,
			16'h0040, 16'h7FFF};
		arst_n = 0; in_valid = 0; distance = 0; last_sample = 0;
		cfg_we = 0; cfg_index = pfa_pkg::REG_START_ANGLE; cfg_data = 0;
		burst_left = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: single-sample scans at the range extremes, reset settings
		foreach (edge_ranges[i]) send_range(edge_ranges[i], 1'b1);
		drain();
		// One-radian steps from the extreme angle walk all quadrants and wrap
		write_reg(pfa_pkg::REG_START_ANGLE, 16'(25736));
		write_reg(pfa_pkg::REG_ANGLE_STEP, 16'd8192);
		for (int i = 0; i < 8; i++) send_range(16'd0, i == 7);
		drain();
		// Start angle written mid-scan must not move the running angle
		write_reg(pfa_pkg::REG_START_ANGLE, 16'h8000);
		write_reg(pfa_pkg::REG_ANGLE_STEP, 16'h3FFF);
		send_range(16'd10, 1'b0);
		send_range(16'd300, 1'b0);
		drain();
		write_reg(pfa_pkg::REG_START_ANGLE, 16'h7FFF);
		send_range(16'd0, 1'b1);
		send_range(16'd0, 1'b1);
		drain();

		// Random phases over a range of register settings
		write_reg(pfa_pkg::REG_START_ANGLE, -16'sd25736);
		write_reg(pfa_pkg::REG_ANGLE_STEP, 16'd71);
		random_scans(200);
		write_reg(pfa_pkg::REG_START_ANGLE, 16'd25736);
		write_reg(pfa_pkg::REG_ANGLE_STEP, 16'd8192);
		random_scans(200);
		write_reg(pfa_pkg::REG_ANGLE_STEP, 16'd0);
		write_reg(pfa_pkg::REG_START_ANGLE, 16'd0);
		random_scans(150);
		write_reg(pfa_pkg::REG_START_ANGLE, 16'h8000);
		write_reg(pfa_pkg::REG_ANGLE_STEP, 16'hFFFF);
		random_scans(150);
		for (int p = 0; p < 5; p++) begin
			write_reg(pfa_pkg::REG_START_ANGLE, 16'($urandom));
			write_reg(pfa_pkg::REG_ANGLE_STEP, 16'($urandom_range(0, 400)));
			random_scans(100);
		end

		drain();
		if (errors == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
